// File: rtl/core/tsa_pkg.sv
package tsa_pkg;

    localparam int IDX_W       = 10;
    localparam int IN_TDATA_W  = 208;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 64;

    localparam int QDEPTH      = 4;
    localparam int QAW         = 2;

    localparam int NUM_LANES   = 3;
    localparam int DIV_N_W     = 58;
    localparam int DIV_D_W     = 35;
    localparam int DIV_CNT_W   = 6;

    localparam int SUM_W       = 48;
    localparam int MAG_SHIFT   = 30;
    localparam int TRI_W       = 86;

    localparam logic [34:0]        DET_MIN = 35'd269;
    localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_TRI   = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
    } t_vertex;

    typedef struct packed {
        t_op              op;
        logic             ok;
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
        logic [IDX_W-1:0] idx_c;
        t_vertex          vtx;
    } t_item;

    typedef struct packed {
        logic               neg;
        logic signed [47:0] sum_x;
        logic signed [47:0] sum_y;
        logic signed [47:0] sum_z;
    } t_acc;

    typedef struct packed {
        logic [IDX_W-1:0]   out_index;
        logic signed [15:0] tan_x;
        logic signed [15:0] tan_y;
        logic signed [15:0] tan_z;
        logic               handed_neg;
    } t_result;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TRI_RD,
        ST_TRI_SUB,
        ST_TRI_MUL,
        ST_TRI_DIF,
        ST_TRI_CHK,
        ST_TRI_DIV,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_RD_WAIT,
        ST_RD_SHIFT,
        ST_RD_SQ,
        ST_RD_SUM,
        ST_RD_ROOT,
        ST_RD_DIVS,
        ST_RD_DIV,
        ST_OUT
    } t_state;

endpackage

// File: rtl/core/tsa_ram.sv
module tsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/tsa_div.sv
module tsa_div
    import tsa_pkg::*;
(
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [NUM_LANES-1:0][DIV_N_W-1:0]     i_dividend,
    input  logic [DIV_D_W-1:0]                    i_divisor,
    output logic                                  o_busy,
    output logic                                  o_done,
    output logic [NUM_LANES-1:0][DIV_N_W-1:0]     o_quot
);

    logic                                r_busy;
    logic                                r_done;
    logic [DIV_CNT_W-1:0]                r_cnt;
    logic [DIV_D_W-1:0]                  r_divisor;
    logic [NUM_LANES-1:0][DIV_D_W-1:0]   r_rem;
    logic [NUM_LANES-1:0][DIV_N_W-1:0]   r_quo;
    logic [NUM_LANES-1:0][DIV_D_W:0]     trial;
    logic [NUM_LANES-1:0]                fits;

    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            trial[k] = {r_rem[k], r_quo[k][DIV_N_W-1]};
            fits[k]  = trial[k] >= {1'b0, r_divisor};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per lane per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_quo     <= i_dividend;
        end else if (r_busy) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                if (fits[k]) begin
                    r_rem[k] <= DIV_D_W'(trial[k] - {1'b0, r_divisor});
                end else begin
                    r_rem[k] <= trial[k][DIV_D_W-1:0];
                end
                r_quo[k] <= {r_quo[k][DIV_N_W-2:0], fits[k]};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// File: rtl/core/tsa_front.sv
module tsa_front
    import tsa_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_TDATA_W-1:0] i_tdata,
    input  logic [IN_TUSER_W-1:0] i_tuser,
    input  logic                  i_boot,
    output logic                  o_item_valid,
    output t_item                 o_item,
    input  logic                  i_pop
);

    t_item            item;
    logic             a_ok;
    logic             b_ok;
    logic             c_ok;
    logic             push;
    t_item            r_q [QDEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QAW:0]     r_count;

    always_comb begin
        item.op         = t_op'(i_tuser);
        item.idx_a      = i_tdata[9:0];
        item.vtx.pos_x  = i_tdata[41:10];
        item.vtx.pos_y  = i_tdata[73:42];
        item.vtx.pos_z  = i_tdata[105:74];
        item.vtx.tex_u  = i_tdata[121:106];
        item.vtx.tex_v  = i_tdata[137:122];
        item.vtx.norm_x = i_tdata[153:138];
        item.vtx.norm_y = i_tdata[169:154];
        item.vtx.norm_z = i_tdata[185:170];
        item.idx_b      = i_tdata[195:186];
        item.idx_c      = i_tdata[205:196];
        a_ok = 32'(item.idx_a) < 32'(MAX_VERTICES);
        b_ok = 32'(item.idx_b) < 32'(MAX_VERTICES);
        c_ok = 32'(item.idx_c) < 32'(MAX_VERTICES);
        case (item.op)
            OP_LOAD, OP_READ: item.ok = a_ok;
            OP_TRI:           item.ok = a_ok && b_ok && c_ok;
            default:          item.ok = 1'b1;
        endcase
    end

    assign o_ready      = (r_count != (QAW+1)'(QDEPTH)) && !i_boot;
    assign push         = i_valid && o_ready;
    assign o_item_valid = r_count != '0;
    assign o_item       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

endmodule

// File: rtl/core/tsa_back.sv
module tsa_back
    import tsa_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_boot,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam logic [AW-1:0] LAST = AW'(MAX_VERTICES - 1);

    t_state r_state;
    t_state n_state;
    logic [AW-1:0] r_clr_addr;
    logic          r_boot;
    logic [2:0]    r_cnt;
    t_item         r_item;

    t_vertex r_va;
    t_vertex r_vb;
    t_vertex r_vc;

    logic signed [32:0] r_e1 [0:2];
    logic signed [32:0] r_e2 [0:2];
    logic signed [16:0] r_du1;
    logic signed [16:0] r_dv1;
    logic signed [16:0] r_du2;
    logic signed [16:0] r_dv2;
    logic signed [33:0] r_pdet_a;
    logic signed [33:0] r_pdet_b;
    logic signed [49:0] r_pa [0:2];
    logic signed [49:0] r_pb [0:2];
    logic signed [48:0] r_pw [0:5];
    logic signed [34:0] r_det;
    logic signed [50:0] r_num [0:2];
    logic signed [49:0] r_w [0:2];
    logic               r_det_neg;
    logic [2:0]         r_num_neg;
    logic signed [TRI_W-1:0] r_prod;
    logic signed [TRI_W-1:0] r_tri;
    logic               r_neg;
    logic signed [50:0] r_t [0:2];

    logic [2:0]         r_sgn;
    logic [SUM_W-1:0]   r_mag [0:2];
    logic [59:0]        r_sq [0:2];
    logic [61:0]        r_rem;
    logic [62:0]        r_root;
    logic [62:0]        r_bit;
    t_result            r_res;
    logic               r_m_valid;
    t_result            r_m_res;

    logic               vert_we;
    logic [AW-1:0]      vert_addr;
    logic [$bits(t_vertex)-1:0] vert_rdata;
    logic               acc_we;
    logic [AW-1:0]      acc_addr;
    t_acc               acc_wdata;
    logic [$bits(t_acc)-1:0] acc_rdata_raw;
    t_acc               acc_rdata;

    logic               div_start;
    logic               div_busy;
    logic               div_done;
    logic [NUM_LANES-1:0][DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic [NUM_LANES-1:0][DIV_N_W-1:0] div_quot;

    logic [34:0]        det_mag;
    logic               det_big;
    logic [50:0]        num_mag [0:2];
    logic               mag_high;
    logic [62:0]        root_trial;
    logic [30:0]        len;
    logic [AW-1:0]      corner;
    logic signed [32:0] mac_e;
    logic signed [49:0] mac_wsel;
    logic signed [25:0] mac_w;
    logic signed [58:0] mac_p;
    logic signed [47:0] rd_sum [0:2];
    logic               out_load;

    function automatic logic signed [47:0] sat_add(input logic signed [47:0] s,
                                                   input logic signed [50:0] t);
        logic signed [51:0] r;
        r = 52'(s) + 52'(t);
        if (r > 52'(SUM_MAX)) begin
            return SUM_MAX;
        end
        if (r < 52'(SUM_MIN)) begin
            return SUM_MIN;
        end
        return 48'(r);
    endfunction

    tsa_ram #(.WIDTH($bits(t_vertex)), .DEPTH(MAX_VERTICES)) u_vert_ram (
        .i_clk   (i_clk),
        .i_we    (vert_we),
        .i_addr  (vert_addr),
        .i_wdata (i_item.vtx),
        .o_rdata (vert_rdata)
    );

    tsa_ram #(.WIDTH($bits(t_acc)), .DEPTH(MAX_VERTICES)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_addr  (acc_addr),
        .i_wdata (acc_wdata),
        .o_rdata (acc_rdata_raw)
    );

    tsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // shared datapath terms
    always_comb begin
        acc_rdata = t_acc'(acc_rdata_raw);
        rd_sum[0] = acc_rdata.sum_x;
        rd_sum[1] = acc_rdata.sum_y;
        rd_sum[2] = acc_rdata.sum_z;
        det_mag = r_det[34] ? 35'(-r_det) : 35'(r_det);
        det_big = det_mag >= DET_MIN;
        for (int k = 0; k < 3; k++) begin
            num_mag[k] = r_num[k][50] ? 51'(-r_num[k]) : 51'(r_num[k]);
        end
        mag_high = (r_mag[0][SUM_W-1:MAG_SHIFT] != '0) ||
                   (r_mag[1][SUM_W-1:MAG_SHIFT] != '0) ||
                   (r_mag[2][SUM_W-1:MAG_SHIFT] != '0);
        root_trial = r_root + r_bit;
        len = r_root[30:0];
        case (r_cnt)
            3'd0:    corner = AW'(r_item.idx_a);
            3'd1:    corner = AW'(r_item.idx_b);
            default: corner = AW'(r_item.idx_c);
        endcase
        case (r_cnt[2:1])
            2'd0: begin
                mac_e    = r_e1[0];
                mac_wsel = r_w[0];
            end
            2'd1: begin
                mac_e    = r_e1[1];
                mac_wsel = r_w[1];
            end
            default: begin
                mac_e    = r_e1[2];
                mac_wsel = r_w[2];
            end
        endcase
        // low half unsigned, high half signed
        mac_w = r_cnt[0] ? $signed({mac_wsel[49], mac_wsel[49:25]})
                         : $signed({1'b0, mac_wsel[24:0]});
        mac_p = mac_e * mac_w;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_item_valid) begin
                    case (i_item.op)
                        OP_CLEAR: n_state = ST_CLEAR;
                        OP_TRI:   n_state = i_item.ok ? ST_TRI_RD : ST_IDLE;
                        OP_READ:  n_state = i_item.ok ? ST_RD_WAIT : ST_OUT;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TRI_RD:   n_state = (r_cnt == 3'd3) ? ST_TRI_SUB : ST_TRI_RD;
            ST_TRI_SUB:  n_state = ST_TRI_MUL;
            ST_TRI_MUL:  n_state = ST_TRI_DIF;
            ST_TRI_DIF:  n_state = ST_TRI_CHK;
            ST_TRI_CHK:  n_state = det_big ? ST_TRI_DIV : ST_IDLE;
            ST_TRI_DIV:  n_state = div_done ? ST_ACC_RD : ST_TRI_DIV;
            ST_ACC_RD:   n_state = ST_ACC_WR;
            ST_ACC_WR:   n_state = (r_cnt == 3'd2) ? ST_IDLE : ST_ACC_RD;
            ST_RD_WAIT:  n_state = ST_RD_SHIFT;
            ST_RD_SHIFT: n_state = mag_high ? ST_RD_SHIFT : ST_RD_SQ;
            ST_RD_SQ:    n_state = ST_RD_SUM;
            ST_RD_SUM:   n_state = ST_RD_ROOT;
            ST_RD_ROOT:  n_state = (r_bit == 63'd1) ? ST_RD_DIVS : ST_RD_ROOT;
            ST_RD_DIVS:  n_state = (len == '0) ? ST_OUT : ST_RD_DIV;
            ST_RD_DIV:   n_state = div_done ? ST_OUT : ST_RD_DIV;
            ST_OUT:      n_state = (!r_m_valid || i_res_ready) ? ST_IDLE : ST_OUT;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        vert_we   = 1'b0;
        vert_addr = AW'(r_item.idx_a);
        acc_we    = 1'b0;
        acc_addr  = corner;
        acc_wdata = '0;
        div_start = 1'b0;
        out_load  = 1'b0;
        if (r_state == ST_TRI_CHK) begin
            for (int k = 0; k < 3; k++) begin
                div_dividend[k] = DIV_N_W'({num_mag[k], 6'b0});
            end
            div_divisor = det_mag;
        end else begin
            for (int k = 0; k < 3; k++) begin
                div_dividend[k] = DIV_N_W'({r_mag[k][29:0], 14'b0}) +
                                  DIV_N_W'(r_root[30:1]);
            end
            div_divisor = DIV_D_W'(len);
        end
        case (r_state)
            ST_CLEAR: begin
                acc_we   = 1'b1;
                acc_addr = r_clr_addr;
            end
            ST_IDLE: begin
                o_pop = i_item_valid;
                if (i_item_valid) begin
                    vert_we   = (i_item.op == OP_LOAD) && i_item.ok;
                    vert_addr = AW'(i_item.idx_a);
                    acc_addr  = AW'(i_item.idx_a);
                end
            end
            ST_TRI_RD: begin
                vert_addr = corner;
            end
            ST_TRI_CHK: begin
                div_start = det_big;
            end
            ST_ACC_WR: begin
                acc_we          = 1'b1;
                acc_wdata.neg   = r_neg;
                acc_wdata.sum_x = sat_add(acc_rdata.sum_x, r_t[0]);
                acc_wdata.sum_y = sat_add(acc_rdata.sum_y, r_t[1]);
                acc_wdata.sum_z = sat_add(acc_rdata.sum_z, r_t[2]);
            end
            ST_RD_DIVS: begin
                div_start = len != '0;
            end
            ST_OUT: begin
                out_load = !r_m_valid || i_res_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_boot     <= 1'b1;
            r_cnt      <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= (r_clr_addr == LAST) ? '0 : r_clr_addr + 1'b1;
                if (r_clr_addr == LAST) begin
                    r_boot <= 1'b0;
                end
            end
            case (r_state)
                ST_TRI_RD:  r_cnt <= r_cnt + 1'b1;
                ST_TRI_DIV: r_cnt <= div_done ? 3'd0 :
                                     ((r_cnt == 3'd7) ? r_cnt : r_cnt + 1'b1);
                // hold the corner between read and write
                ST_ACC_RD:  r_cnt <= r_cnt;
                ST_ACC_WR:  r_cnt <= r_cnt + 1'b1;
                default:    r_cnt <= '0;
            endcase
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_res <= r_res;
        end
        case (r_state)
            ST_IDLE: begin
                r_item          <= i_item;
                r_res.out_index <= i_item.idx_a;
                r_res.tan_x     <= '0;
                r_res.tan_y     <= '0;
                r_res.tan_z     <= '0;
                r_res.handed_neg <= 1'b0;
            end
            ST_TRI_RD: begin
                case (r_cnt)
                    3'd1:    r_va <= t_vertex'(vert_rdata);
                    3'd2:    r_vb <= t_vertex'(vert_rdata);
                    3'd3:    r_vc <= t_vertex'(vert_rdata);
                    default: r_va <= r_va;
                endcase
            end
            ST_TRI_SUB: begin
                r_e1[0] <= 33'(r_vb.pos_x) - 33'(r_va.pos_x);
                r_e1[1] <= 33'(r_vb.pos_y) - 33'(r_va.pos_y);
                r_e1[2] <= 33'(r_vb.pos_z) - 33'(r_va.pos_z);
                r_e2[0] <= 33'(r_vc.pos_x) - 33'(r_va.pos_x);
                r_e2[1] <= 33'(r_vc.pos_y) - 33'(r_va.pos_y);
                r_e2[2] <= 33'(r_vc.pos_z) - 33'(r_va.pos_z);
                r_du1   <= 17'(r_vb.tex_u) - 17'(r_va.tex_u);
                r_dv1   <= 17'(r_vb.tex_v) - 17'(r_va.tex_v);
                r_du2   <= 17'(r_vc.tex_u) - 17'(r_va.tex_u);
                r_dv2   <= 17'(r_vc.tex_v) - 17'(r_va.tex_v);
            end
            ST_TRI_MUL: begin
                r_pdet_a <= r_du1 * r_dv2;
                r_pdet_b <= r_du2 * r_dv1;
                for (int k = 0; k < 3; k++) begin
                    r_pa[k] <= r_e1[k] * r_dv2;
                    r_pb[k] <= r_e2[k] * r_dv1;
                end
                // e2 x N0
                r_pw[0] <= r_e2[1] * r_va.norm_z;
                r_pw[1] <= r_e2[2] * r_va.norm_y;
                r_pw[2] <= r_e2[2] * r_va.norm_x;
                r_pw[3] <= r_e2[0] * r_va.norm_z;
                r_pw[4] <= r_e2[0] * r_va.norm_y;
                r_pw[5] <= r_e2[1] * r_va.norm_x;
            end
            ST_TRI_DIF: begin
                r_det <= 35'(r_pdet_a) - 35'(r_pdet_b);
                for (int k = 0; k < 3; k++) begin
                    r_num[k] <= 51'(r_pa[k]) - 51'(r_pb[k]);
                end
                r_w[0] <= 50'(r_pw[0]) - 50'(r_pw[1]);
                r_w[1] <= 50'(r_pw[2]) - 50'(r_pw[3]);
                r_w[2] <= 50'(r_pw[4]) - 50'(r_pw[5]);
            end
            ST_TRI_CHK: begin
                r_det_neg <= r_det[34];
                for (int k = 0; k < 3; k++) begin
                    r_num_neg[k] <= r_num[k][50];
                end
                r_tri <= '0;
            end
            ST_TRI_DIV: begin
                // triple product e1 . (e2 x N0) in six partial products
                if (r_cnt < 3'd6) begin
                    r_prod <= r_cnt[0] ? (TRI_W'(mac_p) <<< 25) : TRI_W'(mac_p);
                end
                if (r_cnt != 3'd0 && r_cnt != 3'd7) begin
                    r_tri <= r_tri + r_prod;
                end
                if (div_done) begin
                    r_neg <= (r_tri != '0) && (r_tri[TRI_W-1] != r_det_neg);
                    for (int k = 0; k < 3; k++) begin
                        r_t[k] <= (r_num_neg[k] ^ r_det_neg)
                                  ? -$signed(div_quot[k][50:0])
                                  : $signed(div_quot[k][50:0]);
                    end
                end
            end
            ST_RD_WAIT: begin
                r_res.handed_neg <= acc_rdata.neg;
                for (int k = 0; k < 3; k++) begin
                    r_sgn[k] <= rd_sum[k][47];
                    r_mag[k] <= rd_sum[k][47] ? 48'(-rd_sum[k]) : 48'(rd_sum[k]);
                end
            end
            ST_RD_SHIFT: begin
                if (mag_high) begin
                    for (int k = 0; k < 3; k++) begin
                        r_mag[k] <= r_mag[k] >> 1;
                    end
                end
            end
            ST_RD_SQ: begin
                for (int k = 0; k < 3; k++) begin
                    r_sq[k] <= r_mag[k][29:0] * r_mag[k][29:0];
                end
            end
            ST_RD_SUM: begin
                r_rem  <= 62'(r_sq[0]) + 62'(r_sq[1]) + 62'(r_sq[2]);
                r_root <= '0;
                r_bit  <= 63'(1) << 62;
            end
            ST_RD_ROOT: begin
                if (63'(r_rem) >= root_trial) begin
                    r_rem  <= r_rem - 62'(root_trial);
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ST_RD_DIV: begin
                if (div_done) begin
                    r_res.tan_x <= r_sgn[0] ? -$signed(div_quot[0][15:0])
                                            : $signed(div_quot[0][15:0]);
                    r_res.tan_y <= r_sgn[1] ? -$signed(div_quot[1][15:0])
                                            : $signed(div_quot[1][15:0]);
                    r_res.tan_z <= r_sgn[2] ? -$signed(div_quot[2][15:0])
                                            : $signed(div_quot[2][15:0]);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_boot      = r_boot;
    assign o_res_valid = r_m_valid;
    assign o_res       = r_m_res;

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_boot_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_boot |-> !o_pop)
        else $error("command taken during power-up clear");

    a_acc_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC_WR) |-> (acc_addr == AW'(r_item.idx_a)) ||
            (acc_addr == AW'(r_item.idx_b)) || (acc_addr == AW'(r_item.idx_c)))
        else $error("accumulator write outside triangle corners");

endmodule

// File: rtl/core/tangent_space_accumulator.sv
// Channel  Dir  Handshake                           Payload
// s_axis   in   i_s_axis_tvalid / o_s_axis_tready   tdata 208 bits, tuser = cmd
// m_axis   out  o_m_axis_tvalid / i_m_axis_tready   tdata 64 bits
//
// Triangle: runs the 58-step shared divider unless |det| is below DET_MIN.
// Read: up to 18 normalize shifts, 32 square-root steps and the 58-step divider,
// which a zero sum skips. Clear: zeroes all MAX_VERTICES rows, one row at a time.
// After reset the same clearing pass runs with o_s_axis_tready low. A 4-entry
// command queue takes transactions while the back end works; a result register
// lets the next command start under a stall.
module tangent_space_accumulator
    import tsa_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // vert_index, pos_x, pos_y, pos_z, uv_u, uv_v, norm_x, norm_y, norm_z,
    // second_index, third_index, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // cmd
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // out_index, tan_x, tan_y, tan_z, handed_neg, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic    boot;
    logic    item_valid;
    t_item   item;
    logic    pop;
    t_result res;

    tsa_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_tdata      (i_s_axis_tdata),
        .i_tuser      (i_s_axis_tuser),
        .i_boot       (boot),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_pop        (pop)
    );

    tsa_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_pop        (pop),
        .o_boot       (boot),
        .o_res_valid  (o_m_axis_tvalid),
        .o_res        (res),
        .i_res_ready  (i_m_axis_tready)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'({res.handed_neg, res.tan_z, res.tan_y,
                                          res.tan_x, res.out_index});

endmodule

// File: bench/tangent_space_accumulator_tb.sv
`timescale 1ns / 1ps

module tangent_space_accumulator_tb
    import tsa_pkg::*;
();

    class tangent_scoreboard;
        int      pos_x[1024], pos_y[1024], pos_z[1024];
        shortint tex_u[1024], tex_v[1024], nrm_x[1024], nrm_y[1024], nrm_z[1024];
        longint  acc_x[1024], acc_y[1024], acc_z[1024];
        bit      acc_neg[1024];
        logic [OUT_TDATA_W-1:0] tangents_due[$];
        int      errors = 0;

        function longint sat48(longint s, longint t);
            longint r;
            longint hi;
            hi = 64'sh0000_7FFF_FFFF_FFFF;
            r = s + t;
            if (r > hi) return hi;
            if (r < -hi - 1) return -hi - 1;
            return r;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void add_triangle(int a, int b, int c);
            longint e1[3], e2[3], t[3], w[3], n[3];
            longint du1, dv1, du2, dv2, det;
            logic signed [127:0] vol, ea, wa;
            bit neg;
            int corner[3];
            e1[0] = longint'(pos_x[b]) - longint'(pos_x[a]);
            e1[1] = longint'(pos_y[b]) - longint'(pos_y[a]);
            e1[2] = longint'(pos_z[b]) - longint'(pos_z[a]);
            e2[0] = longint'(pos_x[c]) - longint'(pos_x[a]);
            e2[1] = longint'(pos_y[c]) - longint'(pos_y[a]);
            e2[2] = longint'(pos_z[c]) - longint'(pos_z[a]);
            du1 = longint'(tex_u[b]) - longint'(tex_u[a]);
            dv1 = longint'(tex_v[b]) - longint'(tex_v[a]);
            du2 = longint'(tex_u[c]) - longint'(tex_u[a]);
            dv2 = longint'(tex_v[c]) - longint'(tex_v[a]);
            det = du1 * dv2 - du2 * dv1;
            if (det < 269 && det > -269) return;
            for (int k = 0; k < 3; k++) t[k] = ((e1[k] * dv2 - e2[k] * dv1) * 64) / det;
            corner[0] = a; corner[1] = b; corner[2] = c;
            for (int k = 0; k < 3; k++) begin
                acc_x[corner[k]] = sat48(acc_x[corner[k]], t[0]);
                acc_y[corner[k]] = sat48(acc_y[corner[k]], t[1]);
                acc_z[corner[k]] = sat48(acc_z[corner[k]], t[2]);
            end
            // sign of N0 . (e1 x e2), flipped by the sign of det
            n[0] = nrm_x[a]; n[1] = nrm_y[a]; n[2] = nrm_z[a];
            w[0] = e2[1] * n[2] - e2[2] * n[1];
            w[1] = e2[2] * n[0] - e2[0] * n[2];
            w[2] = e2[0] * n[1] - e2[1] * n[0];
            vol = 0;
            for (int k = 0; k < 3; k++) begin
                ea = e1[k];
                wa = w[k];
                vol += ea * wa;
            end
            neg = (vol != 0) && ((vol < 0) != (det < 0));
            for (int k = 0; k < 3; k++) acc_neg[corner[k]] = neg;
        endfunction

        function void note_input(t_op op, logic [IN_TDATA_W-1:0] d);
            int vi;
            longint s[3];
            longint unsigned m[3], mx, sq, len, q;
            int sh;
            logic [15:0] tn[3];
            vi = d[9:0];
            case (op)
                OP_CLEAR: begin
                    for (int i = 0; i < 1024; i++) begin
                        acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0; acc_neg[i] = 0;
                    end
                end
                OP_LOAD: begin
                    pos_x[vi] = d[41:10];   pos_y[vi] = d[73:42];   pos_z[vi] = d[105:74];
                    tex_u[vi] = d[121:106]; tex_v[vi] = d[137:122];
                    nrm_x[vi] = d[153:138]; nrm_y[vi] = d[169:154]; nrm_z[vi] = d[185:170];
                end
                OP_TRI: add_triangle(vi, d[195:186], d[205:196]);
                OP_READ: begin
                    s[0] = acc_x[vi]; s[1] = acc_y[vi]; s[2] = acc_z[vi];
                    for (int k = 0; k < 3; k++) m[k] = s[k] < 0 ? -s[k] : s[k];
                    mx = m[0];
                    if (m[1] > mx) mx = m[1];
                    if (m[2] > mx) mx = m[2];
                    sh = 0;
                    while ((mx >> sh) >= (64'd1 << 30)) sh++;
                    sq = 0;
                    for (int k = 0; k < 3; k++) begin
                        m[k] >>= sh;
                        sq += m[k] * m[k];
                    end
                    len = int_sqrt(sq);
                    for (int k = 0; k < 3; k++) begin
                        tn[k] = 0;
                        if (len != 0) begin
                            q = (m[k] * 16384 + len / 2) / len;
                            tn[k] = s[k] < 0 ? 16'(-q) : 16'(q);
                        end
                    end
                    tangents_due.insert(tangents_due.size(),
                                        {5'd0, acc_neg[vi], tn[2], tn[1], tn[0], 10'(vi)});
                end
            endcase
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] got);
            logic [OUT_TDATA_W-1:0] want;
            if (tangents_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected tangent result %h", got);
                return;
            end
            want = tangents_due.pop_front();
            if (got[9:0] !== want[9:0] || got[25:10] !== want[25:10] ||
                got[41:26] !== want[41:26] || got[57:42] !== want[57:42] ||
                got[58] !== want[58]) begin
                errors++;
                if (errors <= 10)
                    $display("tangent mismatch: idx %0d/%0d t %h %h %h / %h %h %h neg %b/%b",
                             want[9:0], got[9:0], want[25:10], want[41:26], want[57:42],
                             got[25:10], got[41:26], got[57:42], want[58], got[58]);
            end
        endfunction
    endclass

    logic                   i_clk = 0;
    logic                   i_rst_n = 0;
    logic                   i_s_axis_tvalid = 0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  i_s_axis_tuser = OP_CLEAR;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    tangent_space_accumulator dut (.*);

    tangent_scoreboard sb = new();
    bit  quiet = 0;
    bit  src_gaps = 1;
    int  sink_hold = 0;
    bit  loaded[1024];
    int  loaded_list[$];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("[tangent_space_accumulator] ERROR");
        $finish;
    end

    // sink: check on the edge, then pick ready for the next cycle
    initial begin
        int  stall;
        bit  choppy;
        stall = 0;
        choppy = 1;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready) sb.check_result(o_m_axis_tdata);
            if ($urandom_range(0, 199) == 0) choppy = !choppy;
            if (sink_hold > 0) begin
                sink_hold--;
                i_m_axis_tready <= 0;
            end else if (stall > 0) begin
                stall--;
                i_m_axis_tready <= 0;
            end else if (!quiet && choppy && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 7) - 1;
                i_m_axis_tready <= 0;
            end else begin
                i_m_axis_tready <= i_rst_n;
            end
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_item(
        int vi, int px, int py, int pz, shortint u, shortint v,
        shortint nx, shortint ny, shortint nz, int b, int c);
        return {2'b00, 10'(c), 10'(b), 16'(nz), 16'(ny), 16'(nx), 16'(v), 16'(u),
                32'(pz), 32'(py), 32'(px), 10'(vi)};
    endfunction

    task automatic send(t_op op, logic [IN_TDATA_W-1:0] d, bit gaps);
        if (gaps && !quiet && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tdata  <= d;
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(op, d);
        if (op == OP_LOAD && !loaded[d[9:0]]) begin
            loaded[d[9:0]] = 1;
            loaded_list.insert(loaded_list.size(), int'(d[9:0]));
        end
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 0;
        while (sb.tangents_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic int pick_index();
        return $urandom_range(0, 3) != 0 ? $urandom_range(0, 31) : $urandom_range(0, 1023);
    endfunction

    function automatic shortint rand_tex();
        return $urandom_range(0, 1) ? shortint'($urandom) : shortint'($urandom_range(0, 4095));
    endfunction

    task automatic send_random_load(bit gaps);
        shortint nx, ny, nz;
        nx = shortint'($urandom); ny = shortint'($urandom); nz = shortint'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            nx = 0; ny = 0; nz = 0;
        end
        send(OP_LOAD, pack_item(pick_index(), $urandom, $urandom, $urandom, rand_tex(),
                                rand_tex(), nx, ny, nz, $urandom, $urandom), gaps);
    endtask

    initial begin
        int n, sel;
        logic [IN_TDATA_W-1:0] junk;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: untouched read, saturation both ways, clear, det threshold
        send(OP_READ, pack_item(5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send(OP_LOAD, pack_item(0, 32'h8000_0000, 0, 0, 0, 16'sh8000, 0, 0, 0, 0, 0), 0);
        send(OP_LOAD, pack_item(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1,
                                32498, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 0, 0), 0);
        send(OP_LOAD, pack_item(2, 32'h8000_0000, 0, 0, 1, 32767, 0, 0, 0, 0, 0), 0);
        repeat (4) send(OP_TRI, pack_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 2), 0);
        send(OP_READ, pack_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send(OP_LOAD, pack_item(0, 32'h7FFF_FFFF, 0, 0, 0, 16'sh8000,
                                16'sh7FFF, 16'sh7FFF, 16'sh8000, 0, 0), 0);
        send(OP_LOAD, pack_item(1, 32'h8000_0000, 0, 0, 1, 32498, 0, 0, 0, 0, 0), 0);
        send(OP_LOAD, pack_item(2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32767,
                                0, 0, 0, 0, 0), 0);
        repeat (5) send(OP_TRI, pack_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 2), 0);
        send(OP_READ, pack_item(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send(OP_CLEAR, '0, 0);
        send(OP_READ, pack_item(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send(OP_LOAD, pack_item(3, 100, 200, 300, 0, 0, 1000, 2000, 3000, 0, 0), 0);
        send(OP_LOAD, pack_item(4, 70000, -5, 9, 268, 0, 0, 0, 0, 0, 0), 0);
        send(OP_LOAD, pack_item(5, -3, 80000, 1, 0, 1, 0, 0, 0, 0, 0), 0);
        send(OP_LOAD, pack_item(6, 50000, 7, -40000, 269, 0, 0, 0, 0, 0, 0), 0);
        send(OP_TRI, pack_item(3, 0, 0, 0, 0, 0, 0, 0, 0, 4, 5), 0);
        send(OP_TRI, pack_item(3, 0, 0, 0, 0, 0, 0, 0, 0, 6, 5), 0);
        send(OP_TRI, pack_item(3, 0, 0, 0, 0, 0, 0, 0, 0, 5, 6), 0);
        send(OP_READ, pack_item(3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);

        // random: mostly loads and triangles over loaded corners, reads in between
        for (n = 0; n < 2000; n++) begin
            if (n % 100 == 0) src_gaps = $urandom_range(0, 2) != 0;
            if (n == 1700) quiet = 1;
            if (n == 600) begin
                // long sink stall while reads keep coming: queue fills, input backs up
                sink_hold = 500;
                repeat (12) send(OP_READ, pack_item(pick_index(), $urandom, $urandom,
                                 $urandom, shortint'($urandom), shortint'($urandom),
                                 shortint'($urandom), shortint'($urandom),
                                 shortint'($urandom), $urandom, $urandom), 0);
            end
            if (n == 1000) wait_drained();
            junk = IN_TDATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom});
            sel = $urandom_range(0, 199);
            if (sel == 0) begin
                send(OP_CLEAR, junk, src_gaps);
            end else if (sel < 60 || loaded_list.size() < 3) begin
                send_random_load(src_gaps);
            end else if (sel < 150) begin
                junk[9:0]     = 10'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
                junk[195:186] = 10'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
                junk[205:196] = 10'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
                send(OP_TRI, junk, src_gaps);
            end else begin
                junk[9:0] = 10'(pick_index());
                send(OP_READ, junk, src_gaps);
            end
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.tangents_due.size() == 0) begin
            $display("[tangent_space_accumulator] OK");
        end else begin
            $display("[tangent_space_accumulator] ERROR");
        end
        $finish;
    end

endmodule
